@@ design/double_ended_queue_assert.svh @@
// Assertion macros for the double-ended queue.
// Used by the top level; needs a signal named clock and one named reset in scope.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define DEQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deque check failed: same-cycle rule");

// Next-cycle implication, off while reset is high.
`define DEQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deque check failed: next-cycle rule");

`endif

@@ design/deq_pkg.sv @@
// Shared types and codes for the double-ended queue.
// No dependencies; imported by deq_ctrl, deq_datapath and the top level.
`default_nettype none

package deq_pkg;

   localparam int unsigned PortDataWidth  = 64;
   localparam int unsigned PortCountWidth = 5;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_REVERSE    = 3'd4,
      OP_PEEK       = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_SEND = 2'd2
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic apply;   // update state and write the ring for the accepted beat
      logic load;    // read both ends and load the result registers
   } cmd_type;

endpackage

`default_nettype wire

@@ design/double_ended_queue.sv @@
// Top level of the bounded double-ended queue.
// Depends on deq_pkg, deq_ctrl, deq_datapath and double_ended_queue_assert.svh.
`default_nettype none
`include "double_ended_queue_assert.svh"

// A request beat is taken at a clock edge where start is high and busy is low.
// Each beat yields exactly one result: busy is high in the
// cycle after acceptance while the ring memory reads the front and back
// slots through its registered read ports, and in the cycle after that
// rsp_strobe is high for exactly one cycle with the result on the rsp_ ports.
// The receiver cannot stall; sample the result while rsp_strobe is high.
// A new beat may be issued in the same cycle that a result is shown, but not
// while busy is high, since the ring memory is still reading the last beat.
// Push on full returns status 1 and pop on empty returns status 2; both leave
// the contents unchanged. Reverse only flips the orientation. Opcodes 6 and 7
// act as peek. front/back data read zero when the deque is empty.
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [2:0]                req_opcode,
   input  wire logic [PortDataWidth-1:0]  req_push_data,
   output logic                           rsp_strobe,
   output logic [PortDataWidth-1:0]       rsp_front_data,
   output logic [PortDataWidth-1:0]       rsp_back_data,
   output logic [PortCountWidth-1:0]      rsp_entry_count,
   output logic                           rsp_is_empty,
   output logic [1:0]                     rsp_status
);

   cmd_type cmd;

   // Sequencer: accept, read both ends, present the result.
   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // Ring storage and result registers.
   deq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_opcode      (req_opcode),
      .req_push_data   (req_push_data),
      .rsp_front_data  (rsp_front_data),
      .rsp_back_data   (rsp_back_data),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

   // An accepted beat goes straight to the read cycle.
   `DEQ_ASSERT_NEXT(a_accept_reads, start && !busy, busy && cmd.load)
   // The read cycle always ends in exactly one result strobe.
   `DEQ_ASSERT_NEXT(a_read_then_strobe, busy, rsp_strobe && !busy)
   // A refused pop means the deque was, and still is, empty.
   `DEQ_ASSERT_NOW(a_pop_refused_empty, rsp_strobe && (rsp_status == STATUS_EMPTY),
                   rsp_is_empty && (rsp_front_data == '0))

endmodule

`default_nettype wire

@@ design/deq_ctrl.sv @@
// Request sequencer for the double-ended queue.
// Depends on deq_pkg.
`default_nettype none

module deq_ctrl
   import deq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output logic         rsp_strobe,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      busy       = 1'b0;
      rsp_strobe = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.apply = 1'b1;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            busy     = 1'b1;
            cmd.load = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            rsp_strobe = 1'b1;
            if (start) begin
               cmd.apply = 1'b1;
               state_in  = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ design/deq_datapath.sv @@
// Ring storage, head/count/orientation registers and result registers.
// Depends on deq_pkg.
`default_nettype none

module deq_datapath
   import deq_pkg::*;
#(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cmd_type                    cmd,
   input  wire logic [2:0]                 req_opcode,
   input  wire logic [PortDataWidth-1:0]   req_push_data,
   output logic [PortDataWidth-1:0]        rsp_front_data,
   output logic [PortDataWidth-1:0]        rsp_back_data,
   output logic [PortCountWidth-1:0]       rsp_entry_count,
   output logic                            rsp_is_empty,
   output logic [1:0]                      rsp_status
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned SW = CW + 1;

   logic [DATA_WIDTH-1:0] entry_ram [DEPTH];

   logic [AW-1:0] head_ff,   head_in;
   logic [CW-1:0] count_ff,  count_in;
   logic          rev_ff,    rev_in;
   status_type    status_ff, status_in;

   logic [DATA_WIDTH-1:0]     front_ff, back_ff;
   logic [PortCountWidth-1:0] out_count_ff;
   logic                      out_empty_ff;
   status_type                out_status_ff;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;

   logic          is_full, is_empty, at_front, on_first;
   logic [AW-1:0] head_dec, head_inc, tail_slot, last_slot, front_addr, back_addr;
   logic [SW-1:0] end_sum, last_sum;

   // Ring arithmetic; sums stay below twice DEPTH, so one subtract wraps them.
   always_comb begin
      is_full  = (count_ff == CW'(DEPTH));
      is_empty = (count_ff == '0);
      head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
      head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
      end_sum  = SW'(head_ff) + SW'(count_ff);
      tail_slot = (end_sum >= SW'(DEPTH)) ? AW'(end_sum - SW'(DEPTH)) : AW'(end_sum);
      last_sum = end_sum - SW'(1);
      if (is_empty) begin
         last_slot = head_ff;
      end else if (last_sum >= SW'(DEPTH)) begin
         last_slot = AW'(last_sum - SW'(DEPTH));
      end else begin
         last_slot = AW'(last_sum);
      end
      front_addr = rev_ff ? last_slot : head_ff;
      back_addr  = rev_ff ? head_ff : last_slot;
   end

   // Apply one request beat.
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      rev_in    = rev_ff;
      status_in = STATUS_DONE;
      wr_en     = 1'b0;
      wr_addr   = tail_slot;
      wr_data   = req_push_data[DATA_WIDTH-1:0];
      at_front  = (req_opcode == OP_PUSH_FRONT) || (req_opcode == OP_POP_FRONT);
      on_first  = at_front != rev_ff;
      case (req_opcode)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en    = cmd.apply;
               count_in = count_ff + CW'(1);
               if (on_first) begin
                  head_in = head_dec;
                  wr_addr = head_dec;
               end
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
               if (on_first) begin
                  head_in = head_inc;
               end
            end
         end
         OP_REVERSE: begin
            rev_in = ~rev_ff;
         end
         default: begin
            // peek and unused codes: hold state
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else if (cmd.apply) begin
         head_ff  <= head_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ram[wr_addr] <= wr_data;
      end
   end

   // Two registered read ports, one per end.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         front_ff      <= entry_ram[front_addr];
         back_ff       <= entry_ram[back_addr];
         out_count_ff  <= PortCountWidth'(count_ff);
         out_empty_ff  <= is_empty;
         out_status_ff <= status_ff;
      end
   end

   assign rsp_front_data  = out_empty_ff ? '0 : PortDataWidth'(front_ff);
   assign rsp_back_data   = out_empty_ff ? '0 : PortDataWidth'(back_ff);
   assign rsp_entry_count = out_count_ff;
   assign rsp_is_empty    = out_empty_ff;
   assign rsp_status      = out_status_ff;

endmodule

`default_nettype wire

@@ tb/double_ended_queue_test.sv @@
// Self-checking bench for the bounded double-ended queue (double_ended_queue).
// Depends on deq_pkg and the RTL; keeps a shadow deque and checks every response beat.
`default_nettype none

module double_ended_queue_test;
   import deq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RING_DEPTH  = 16;
   localparam int unsigned CYCLE_LIMIT = 400000;

   // Opcodes outside the enum; the block treats them as peek.
   localparam logic [2:0] OP_UNUSED_A = 3'd6;
   localparam logic [2:0] OP_UNUSED_B = 3'd7;

   // One response beat as the block should present it.
   typedef struct packed {
      logic [PortDataWidth-1:0]  front;
      logic [PortDataWidth-1:0]  back;
      logic [PortCountWidth-1:0] count;
      logic                      empty;
      logic [1:0]                status;
   } deque_view_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [2:0]                req_opcode = OP_PEEK;
   logic [PortDataWidth-1:0]  req_push_data = '0;
   logic                      rsp_strobe;
   logic [PortDataWidth-1:0]  rsp_front_data;
   logic [PortDataWidth-1:0]  rsp_back_data;
   logic [PortCountWidth-1:0] rsp_entry_count;
   logic                      rsp_is_empty;
   logic [1:0]                rsp_status;

   // Shadow copy of the deque: ring, head slot, live count and orientation.
   logic [PortDataWidth-1:0]  shadow_ring [RING_DEPTH];
   logic [3:0]                shadow_head = '0;
   logic [PortCountWidth-1:0] shadow_count = '0;
   logic                      shadow_flipped = 1'b0;

   deque_view_type awaited_views [$];
   int unsigned failures = 0;
   int unsigned cycle_count = 0;
   bit          gaps_on = 1'b1;

   double_ended_queue #(
      .DEPTH      (RING_DEPTH),
      .DATA_WIDTH (PortDataWidth)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_push_data   (req_push_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_front_data  (rsp_front_data),
      .rsp_back_data   (rsp_back_data),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one request to the shadow deque and return the view the block owes.
   task automatic apply_to_shadow_deque(input logic [2:0] op, input logic [63:0] data,
                                        output deque_view_type view);
      logic [3:0] last_slot;
      logic       at_front;
      view.status = STATUS_DONE;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_count >= RING_DEPTH) begin
               view.status = STATUS_FULL;
            end else begin
               at_front = (op == OP_PUSH_FRONT);
               // Flipped orientation turns a front push into a push at the stored end.
               if (at_front != shadow_flipped) begin
                  shadow_head = shadow_head - 4'd1;
                  shadow_ring[shadow_head] = data;
               end else begin
                  shadow_ring[shadow_head + shadow_count[3:0]] = data;
               end
               shadow_count = shadow_count + 5'd1;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (shadow_count == 0) begin
               view.status = STATUS_EMPTY;
            end else begin
               at_front = (op == OP_POP_FRONT);
               if (at_front != shadow_flipped) shadow_head = shadow_head + 4'd1;
               shadow_count = shadow_count - 5'd1;
            end
         end
         OP_REVERSE: shadow_flipped = ~shadow_flipped;
         default: ;   // peek and the unused codes change nothing
      endcase

      last_slot = shadow_head + 4'(shadow_count - 5'd1);
      if (shadow_count == 0) begin
         view.front = '0;
         view.back  = '0;
      end else if (!shadow_flipped) begin
         view.front = shadow_ring[shadow_head];
         view.back  = shadow_ring[last_slot];
      end else begin
         view.front = shadow_ring[last_slot];
         view.back  = shadow_ring[shadow_head];
      end
      view.count = shadow_count;
      view.empty = (shadow_count == 0);
   endtask

   // Send one request beat: idle for a random gap, then hold start until accepted.
   task automatic send_request(input logic [2:0] op, input logic [63:0] data);
      int unsigned idle_cycles;
      deque_view_type view;
      idle_cycles = gaps_on ? $urandom_range(0, 14) : 0;
      if (idle_cycles != 0) begin
         start <= 1'b0;
         repeat (idle_cycles) @(posedge clock);
      end
      start         <= 1'b1;
      req_opcode    <= op;
      req_push_data <= data;
      do @(posedge clock); while (busy);
      apply_to_shadow_deque(op, data, view);
      awaited_views.push_back(view);
   endtask

   // Drop start and hold off until every awaited response beat has arrived.
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (awaited_views.size() != 0);
   endtask

   function automatic logic [63:0] random_word();
      int unsigned pick;
      logic [63:0] one_hot;
      pick    = $urandom_range(0, 9);
      one_hot = 64'd1 << $urandom_range(0, 63);
      case (pick)
         0: return '0;
         1: return '1;
         2: return one_hot;
         3: return ~one_hot;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [2:0] random_push();
      return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
   endfunction

   function automatic logic [2:0] random_pop();
      return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
   endfunction

   task automatic report_field(input string name, input logic [63:0] expv,
                               input logic [63:0] gotv);
      if (gotv !== expv) begin
         failures++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, expv, gotv);
      end
   endtask

   // Check every response beat against the oldest awaited view; values are the
   // ones present just before the edge, so the check does not race the RTL.
   always @(posedge clock) begin
      deque_view_type exp_view;
      if (!reset && rsp_strobe) begin
         if (awaited_views.size() == 0) begin
            failures++;
            $display("%0t: response beat with nothing awaited, expected none, got count %0d",
                     $time, rsp_entry_count);
         end else begin
            exp_view = awaited_views.pop_front();
            report_field("front_data", exp_view.front, rsp_front_data);
            report_field("back_data", exp_view.back, rsp_back_data);
            report_field("entry_count", 64'(exp_view.count), 64'(rsp_entry_count));
            report_field("is_empty", 64'(exp_view.empty), 64'(rsp_is_empty));
            report_field("status", 64'(exp_view.status), 64'(rsp_status));
         end
      end
   end

   // Watchdog: end the run if responses stop coming.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, awaited_views.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Empty-deque corner cases, reverse on empty, pushes under flipped
   // orientation, the unused opcodes and the data extremes.
   task automatic test_directed();
      gaps_on = 1'b1;
      send_request(OP_POP_FRONT, '0);
      send_request(OP_POP_BACK, '1);
      send_request(OP_PEEK, '0);
      send_request(OP_REVERSE, '0);
      send_request(OP_PUSH_FRONT, '1);
      send_request(OP_PUSH_BACK, '0);
      send_request(OP_PEEK, '1);
      send_request(OP_UNUSED_A, 64'h5555_5555_5555_5555);
      send_request(OP_UNUSED_B, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(OP_REVERSE, '1);
      send_request(OP_POP_FRONT, '0);
      send_request(OP_POP_BACK, '0);
      send_request(OP_PUSH_BACK, 64'h8000_0000_0000_0001);
      send_request(OP_PUSH_FRONT, 64'h7FFF_FFFF_FFFF_FFFE);
      send_request(OP_POP_BACK, '0);
      send_request(OP_POP_FRONT, '0);
   endtask

   // Fill to capacity, push into a full ring, drain, pop an empty ring;
   // reverses are sprinkled in so the ends swap under load.
   task automatic test_fill_and_drain();
      for (int round = 0; round < 8; round++) begin
         gaps_on = round[0];
         while (shadow_count < RING_DEPTH) begin
            send_request(random_push(), random_word());
            if ($urandom_range(0, 7) == 0) send_request(OP_REVERSE, random_word());
         end
         repeat ($urandom_range(1, 3)) send_request(random_push(), random_word());
         send_request(OP_PEEK, random_word());
         while (shadow_count != 0) begin
            send_request(random_pop(), random_word());
            if ($urandom_range(0, 7) == 0) send_request(OP_REVERSE, random_word());
         end
         repeat ($urandom_range(1, 3)) send_request(random_pop(), random_word());
      end
   endtask

   // Random walk over all opcodes; each segment leans toward filling or
   // emptying, and the sender drains fully between segments.
   task automatic test_random_mix();
      int unsigned push_weight;
      int unsigned roll;
      logic [2:0]  op;
      for (int segment = 0; segment < 15; segment++) begin
         gaps_on = ($urandom_range(0, 2) != 0);
         case ($urandom_range(0, 2))
            0: push_weight = 20;
            1: push_weight = 45;
            default: push_weight = 70;
         endcase
         repeat (100) begin
            roll = $urandom_range(0, 99);
            if (roll < push_weight) op = random_push();
            else if (roll < 85) op = random_pop();
            else if (roll < 92) op = OP_REVERSE;
            else if (roll < 97) op = OP_PEEK;
            else op = $urandom_range(0, 1) ? OP_UNUSED_B : OP_UNUSED_A;
            send_request(op, random_word());
         end
         wait_for_drain();
      end
   endtask

   initial begin
      foreach (shadow_ring[i]) shadow_ring[i] = '0;
      // Hold reset from the start, then release it at an edge.
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_and_drain();
      test_random_mix();

      // Let the last response beats land, then wait on for any stray beats.
      wait_for_drain();
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
